// ===== sv/sca_pkg.sv =====
// Shared types, sizes and codes for the sound channel allocator.
// No dependencies; sca_eval and sound_channel_allocator import this package.
package sca_pkg;

  // Voice table size and derived widths
  localparam int VOICES = 32;
  localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CNT_W  = $clog2(VOICES + 1);

  // Field widths
  localparam int ENT_W  = 10;
  localparam int CHAN_W = 8;
  localparam int LEN_W  = 24;
  localparam int NOW_W  = 31;
  localparam int TIME_W = 32;
  localparam int REL_W  = 5;
  localparam int OIDX_W = 5;

  // Action codes
  localparam logic [1:0] ACT_REQ = 2'd0;
  localparam logic [1:0] ACT_REL = 2'd1;
  localparam logic [1:0] ACT_CLR = 2'd2;

  // Status codes
  localparam logic [1:0] ST_GRANT = 2'd0;
  localparam logic [1:0] ST_NONE  = 2'd1;
  localparam logic [1:0] ST_DONE  = 2'd2;

  // Life compare: keys are life with the sign bit flipped
  localparam logic [TIME_W-1:0] SIGN_FLIP = 32'h8000_0000;
  localparam logic [TIME_W-1:0] BEST_INIT = 32'h7fff_ffff ^ SIGN_FLIP;

  localparam logic [ENT_W-1:0] PLAYER_RESET = 10'd1;

  // One stored voice (active flag lives in the valid bits)
  typedef struct packed {
    logic [ENT_W-1:0]  ent;
    logic [CHAN_W-1:0] chan;
    logic [TIME_W-1:0] end_time;
  } voice_t;

  localparam int VOICE_W = $bits(voice_t);

  // Latched request
  typedef struct packed {
    logic [ENT_W-1:0]  ent;
    logic [CHAN_W-1:0] chan;
    logic [LEN_W-1:0]  len;
    logic [NOW_W-1:0]  now;
  } req_t;

  // Verdict of the compare unit on one voice
  typedef struct packed {
    logic              match;
    logic              take;
    logic [TIME_W-1:0] key;
  } eval_t;

endpackage

// ===== sv/sca_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module sca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/sca_eval.sv =====
// Shared compare unit: judges one voice against the pending request.
// Depends on sca_pkg.
module sca_eval
  import sca_pkg::*;
(
  input  voice_t            entry,
  input  logic              active,
  input  req_t              req,
  input  logic [ENT_W-1:0]  player,
  input  logic [TIME_W-1:0] best,
  output eval_t             verdict
);

  logic              skip;
  logic [TIME_W-1:0] life;

  // Same entity and same non-zero channel replaces at once
  assign verdict.match = (req.chan != '0) && (entry.ent == req.ent) &&
                         (entry.chan == req.chan);

  // Protect active player voices from other entities
  assign skip = active && (entry.ent == player) && (req.ent != player);

  // Signed remaining life turned into an unsigned order key
  assign life        = entry.end_time - {1'b0, req.now};
  assign verdict.key = life ^ SIGN_FLIP;
  assign verdict.take = !skip && (verdict.key < best);

endmodule

// ===== sv/sound_channel_allocator.sv =====
// Sound channel allocator: a 32-voice mixer table with voice stealing.
// Release and clear-all words go from the idle state straight to the result
// state. A request walks the voice table one entry per cycle through a single
// compare unit fed by the table RAM's read port, then passes the write state
// and the result state; when no voice qualifies, the write state is skipped.
// A voice with the same entity and non-zero channel ends the scan at that
// voice. The next word can be taken in the idle state once the result is
// loaded. The block takes no new word while a request is being worked. The
// result sits in an output register, so a stalled consumer does not hold back
// acceptance of the next word; the result after that waits in the result
// state. Voice valid bits clear at reset and on clear-all, so no clearing
// pass is needed.
// Depends on sca_pkg, sca_ram and sca_eval.
module sound_channel_allocator
  import sca_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              cfg_wr_en,
  input  logic [ENT_W-1:0]  cfg_wr_data,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        action,
  input  logic [ENT_W-1:0]  entity,
  input  logic [CHAN_W-1:0] entity_channel,
  input  logic [LEN_W-1:0]  sound_length,
  input  logic [NOW_W-1:0]  now,
  input  logic [REL_W-1:0]  voice_to_release,
  // output channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        status,
  output logic [OIDX_W-1:0] voice_index
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_DONE
  } state_t;

  state_t             state;
  logic [ENT_W-1:0]   player;
  logic [VOICES-1:0]  vld;
  req_t               req;
  logic [CNT_W-1:0]   issue;
  logic               ev_pend;
  logic [VIDX_W-1:0]  ev_idx;
  logic               rd_act;
  logic [TIME_W-1:0]  best;
  logic               found;
  logic [VIDX_W-1:0]  pick;
  logic [1:0]         res_status;
  logic [OIDX_W-1:0]  res_idx;

  logic               ram_re;
  logic               ram_we;
  voice_t             ram_wdata;
  logic [VOICE_W-1:0] ram_rdata;
  voice_t             entry;
  eval_t              verdict;
  logic               rel_in_range;
  logic               last_eval;

  // Accept only while idle
  assign in_stall = (state != S_IDLE);

  // Read one voice per scan cycle, write the chosen voice afterwards
  assign ram_re    = (state == S_SCAN) && (issue != CNT_W'(VOICES));
  assign ram_we    = (state == S_WRITE);
  assign ram_wdata = '{ent: req.ent, chan: req.chan,
                       end_time: {1'b0, req.now} + {{(TIME_W-LEN_W){1'b0}}, req.len}};

  sca_ram #(
    .WIDTH(VOICE_W),
    .DEPTH(VOICES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(pick),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(issue[VIDX_W-1:0]),
    .rdata(ram_rdata)
  );

  // Freed voices read as all zero
  assign entry = rd_act ? voice_t'(ram_rdata) : '0;

  sca_eval u_eval (
    .entry  (entry),
    .active (rd_act),
    .req    (req),
    .player (player),
    .best   (best),
    .verdict(verdict)
  );

  assign rel_in_range = 32'(voice_to_release) < VOICES;
  assign last_eval    = (ev_idx == VIDX_W'(VOICES - 1));

  // Sequencer, voice valid bits and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      player    <= PLAYER_RESET;
      vld       <= '0;
      out_valid <= 1'b0;
      ev_pend   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        player <= cfg_wr_data;
      end
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req        <= '{ent: entity, chan: entity_channel,
                            len: sound_length, now: now};
            issue      <= '0;
            ev_pend    <= 1'b0;
            best       <= BEST_INIT;
            found      <= 1'b0;
            pick       <= '0;
            res_status <= ST_NONE;
            res_idx    <= '0;
            case (action)
              ACT_REQ: begin
                state <= S_SCAN;
              end
              ACT_REL: begin
                if (rel_in_range) begin
                  vld[VIDX_W'(voice_to_release)] <= 1'b0;
                end
                res_status <= ST_DONE;
                state      <= S_DONE;
              end
              ACT_CLR: begin
                vld        <= '0;
                res_status <= ST_DONE;
                state      <= S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          // issue stage: advance the read address
          if (ram_re) begin
            issue   <= issue + 1'b1;
            ev_idx  <= issue[VIDX_W-1:0];
            rd_act  <= vld[issue[VIDX_W-1:0]];
            ev_pend <= 1'b1;
          end else begin
            ev_pend <= 1'b0;
          end
          // evaluate stage: judge the voice read last cycle
          if (ev_pend) begin
            if (verdict.match) begin
              pick  <= ev_idx;
              found <= 1'b1;
              state <= S_WRITE;
            end else begin
              if (verdict.take) begin
                best  <= verdict.key;
                pick  <= ev_idx;
                found <= 1'b1;
              end
              if (last_eval) begin
                state <= (found || verdict.take) ? S_WRITE : S_DONE;
              end
            end
          end
        end
        S_WRITE: begin
          vld[pick]  <= 1'b1;
          res_status <= ST_GRANT;
          res_idx    <= OIDX_W'(pick);
          state      <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            voice_index <= res_idx;
            state       <= S_IDLE;
          end
        end
      endcase
    end
  end

  // A result appears only out of the result state
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result word raised outside the result state");

  // Only a grant carries a voice index
  a_idx_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_GRANT)) |-> (voice_index == '0))
    else $error("voice index set on a non-grant result");

  // The running best never grows during a scan
  a_best_falls: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN) && $past(state == S_SCAN)) |-> (best <= $past(best)))
    else $error("running best life increased during scan");

  // A granted voice is marked active
  a_grant_active: assert property (@(posedge clk) disable iff (rst)
    ($past(state == S_WRITE) && !$past(rst)) |-> vld[$past(pick)])
    else $error("granted voice not marked active");

endmodule
